### hdl/dspd_pkg.sv
`default_nettype none

package dspd_pkg;

   // Field and register widths.
   localparam int POS_W  = 24;
   localparam int ERR_W  = POS_W + 1;
   localparam int DER_W  = ERR_W + 1;
   localparam int INT_W  = 21;
   localparam int ACC_W  = ERR_W + 1;
   localparam int GAIN_W = 12;
   localparam int LIM_W  = 7;
   localparam int ZONE_W = 16;
   localparam int DRV_W  = 8;
   localparam int CSR_W  = 24;
   localparam int IDX_W  = 3;

   // Product and sum widths; the gains are unsigned Q4.8.
   localparam int FRAC_W = 8;
   localparam int P_W    = GAIN_W + 1 + ERR_W;
   localparam int I_W    = GAIN_W + 1 + INT_W;
   localparam int D_W    = GAIN_W + 1 + DER_W;
   localparam int SUM_W  = D_W + 2;
   localparam int Q_W    = SUM_W - FRAC_W;

   // Integral saturation bounds.
   localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
   localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

   // Settling thresholds on error and derivative magnitude.
   localparam logic [ERR_W-1:0] ERR_SETTLE = ERR_W'(10);
   localparam logic [DER_W-1:0] DER_SETTLE = DER_W'(5);

   // Register reset values.
   localparam logic [LIM_W-1:0]  LIMIT_RESET  = LIM_W'(127);
   localparam logic [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(102);
   localparam logic [GAIN_W-1:0] GAIN_I_RESET = GAIN_W'(44);
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = GAIN_W'(64);
   localparam logic [ZONE_W-1:0] ZONE_RESET   = ZONE_W'(50);

   // Register indexes of the configuration port.
   typedef enum logic [IDX_W-1:0] {
      CSR_TARGET_LEFT   = 3'd0,
      CSR_TARGET_RIGHT  = 3'd1,
      CSR_LIMIT_LEFT    = 3'd2,
      CSR_LIMIT_RIGHT   = 3'd3,
      CSR_GAIN_P        = 3'd4,
      CSR_GAIN_I        = 3'd5,
      CSR_GAIN_D        = 3'd6,
      CSR_INTEGRAL_ZONE = 3'd7
   } dspd_csr_type;

   // Stage strobes shared by both side pipelines.
   typedef struct packed {
      logic restart;
      logic ld_state;
      logic ld_prod;
      logic ld_out;
   } dspd_ctrl_type;

endpackage

`default_nettype wire

### hdl/dspd_error.sv
`default_nettype none

module dspd_error
   import dspd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    load,
   input  wire logic signed [POS_W-1:0] target_left,
   input  wire logic signed [POS_W-1:0] target_right,
   input  wire logic signed [POS_W-1:0] left_front_position,
   input  wire logic signed [POS_W-1:0] left_back_position,
   input  wire logic signed [POS_W-1:0] right_front_position,
   input  wire logic signed [POS_W-1:0] right_back_position,
   output logic signed [ERR_W-1:0]      err_left,
   output logic signed [ERR_W-1:0]      err_right
);

   logic [ERR_W-1:0] sum_left;
   logic [ERR_W-1:0] sum_right;
   logic [POS_W-1:0] half_left;
   logic [POS_W-1:0] half_right;
   logic [ERR_W-1:0] err_left_in;
   logic [ERR_W-1:0] err_right_in;
   logic [ERR_W-1:0] err_left_ff;
   logic [ERR_W-1:0] err_right_ff;

   // Average each encoder pair; dropping the low bit floors the half.
   always_comb begin
      sum_left   = {left_front_position[POS_W-1], left_front_position}
                 + {left_back_position[POS_W-1], left_back_position};
      sum_right  = {right_front_position[POS_W-1], right_front_position}
                 + {right_back_position[POS_W-1], right_back_position};
      half_left  = sum_left[ERR_W-1:1];
      half_right = sum_right[ERR_W-1:1];
      // The right motors are reversed, so its negated position adds back in.
      err_left_in  = {target_left[POS_W-1], target_left}
                   - {half_left[POS_W-1], half_left};
      err_right_in = {target_right[POS_W-1], target_right}
                   + {half_right[POS_W-1], half_right};
   end

   // Error stage register.
   always_ff @(posedge clock) begin
      if (load) begin
         err_left_ff  <= err_left_in;
         err_right_ff <= err_right_in;
      end
   end

   assign err_left  = $signed(err_left_ff);
   assign err_right = $signed(err_right_ff);

endmodule

`default_nettype wire

### hdl/dspd_side.sv
`default_nettype none

module dspd_side
   import dspd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dspd_ctrl_type           ctrl,
   input  wire logic signed [ERR_W-1:0] err,
   input  wire logic [GAIN_W-1:0]       gain_p,
   input  wire logic [GAIN_W-1:0]       gain_i,
   input  wire logic [GAIN_W-1:0]       gain_d,
   input  wire logic [ZONE_W-1:0]       integral_zone,
   input  wire logic [LIM_W-1:0]        limit,
   output logic [DRV_W-1:0]             drive,
   output logic                         settled
);

   // Controller state carried from tick to tick.
   logic [ERR_W-1:0] last_error_ff;
   logic [INT_W-1:0] integral_ff;

   // State stage.
   logic [ERR_W-1:0] last_sel;
   logic [INT_W-1:0] integ_base;
   logic [DER_W-1:0] der_in;
   logic [ERR_W-1:0] err_abs;
   logic [DER_W-1:0] der_abs;
   logic [ACC_W-1:0] acc;
   logic [INT_W-1:0] acc_sat;
   logic [INT_W-1:0] integ_in;
   logic             settled_in;
   logic signed [ERR_W-1:0] err_s2_ff;
   logic signed [DER_W-1:0] der_s2_ff;
   logic signed [INT_W-1:0] integ_s2_ff;
   logic                    settled_s2_ff;

   // Product stage.
   logic signed [P_W-1:0] prod_p_in;
   logic signed [I_W-1:0] prod_i_in;
   logic signed [D_W-1:0] prod_d_in;
   logic signed [P_W-1:0] prod_p_ff;
   logic signed [I_W-1:0] prod_i_ff;
   logic signed [D_W-1:0] prod_d_ff;
   logic                  settled_s3_ff;

   // Output stage.
   logic [SUM_W-1:0]        sum;
   logic signed [Q_W-1:0]   quot;
   logic signed [Q_W-1:0]   lim_pos;
   logic signed [Q_W-1:0]   lim_neg;
   logic [DRV_W-1:0]        drive_in;
   logic [DRV_W-1:0]        drive_ff;
   logic                    settled_ff;

   // Derivative, integral zone with saturation, and the settling test.
   always_comb begin
      last_sel   = ctrl.restart ? err : last_error_ff;
      integ_base = ctrl.restart ? '0 : integral_ff;
      der_in     = {err[ERR_W-1], err} - {last_sel[ERR_W-1], last_sel};
      err_abs    = err[ERR_W-1] ? (~err + ERR_W'(1)) : err;
      der_abs    = der_in[DER_W-1] ? (~der_in + DER_W'(1)) : der_in;
      acc        = {{(ACC_W-INT_W){integ_base[INT_W-1]}}, integ_base}
                 + {{(ACC_W-ERR_W){err[ERR_W-1]}}, err};
      // The sum fits when every bit above the integral's sign agrees with it.
      if ((acc[ACC_W-1:INT_W-1] == '0) || (acc[ACC_W-1:INT_W-1] == '1)) begin
         acc_sat = acc[INT_W-1:0];
      end else begin
         acc_sat = acc[ACC_W-1] ? INT_MIN : INT_MAX;
      end
      integ_in   = (err_abs < {{(ERR_W-ZONE_W){1'b0}}, integral_zone}) ? acc_sat
                                                                       : integ_base;
      settled_in = (err_abs < ERR_SETTLE) && (der_abs < DER_SETTLE);
   end

   // The state moves only when a beat enters the state stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         integral_ff   <= '0;
      end else if (ctrl.ld_state) begin
         last_error_ff <= err;
         integral_ff   <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_state) begin
         err_s2_ff     <= err;
         der_s2_ff     <= $signed(der_in);
         integ_s2_ff   <= $signed(integ_in);
         settled_s2_ff <= settled_in;
      end
   end

   // Three gain multiplies, each registered.
   assign prod_p_in = $signed({1'b0, gain_p}) * err_s2_ff;
   assign prod_i_in = $signed({1'b0, gain_i}) * integ_s2_ff;
   assign prod_d_in = $signed({1'b0, gain_d}) * der_s2_ff;

   always_ff @(posedge clock) begin
      if (ctrl.ld_prod) begin
         prod_p_ff     <= prod_p_in;
         prod_i_ff     <= prod_i_in;
         prod_d_ff     <= prod_d_in;
         settled_s3_ff <= settled_s2_ff;
      end
   end

   // Sum, floor by the Q4.8 scale, clamp to the symmetric limit.
   always_comb begin
      sum = {{(SUM_W-P_W){prod_p_ff[P_W-1]}}, prod_p_ff}
          + {{(SUM_W-I_W){prod_i_ff[I_W-1]}}, prod_i_ff}
          + {{(SUM_W-D_W){prod_d_ff[D_W-1]}}, prod_d_ff};
      quot    = $signed(sum[SUM_W-1:FRAC_W]);
      lim_pos = $signed({{(Q_W-LIM_W){1'b0}}, limit});
      lim_neg = -lim_pos;
      priority if (quot > lim_pos) begin
         drive_in = lim_pos[DRV_W-1:0];
      end else if (quot < lim_neg) begin
         drive_in = lim_neg[DRV_W-1:0];
      end else begin
         drive_in = quot[DRV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_out) begin
         drive_ff   <= drive_in;
         settled_ff <= settled_s3_ff;
      end
   end

   assign drive   = drive_ff;
   assign settled = settled_ff;

endmodule

`default_nettype wire

### hdl/dual_side_pid_drive.sv
// Two-side PID position controller with an integral zone. Each req beat is
// one control tick carrying four encoder positions and a restart flag; each
// tick yields exactly one rsp beat with the clamped left and right drive
// commands and the moving flag. The block is a five-register pipeline
// (input, error, state, products, output); a new tick can be accepted
// every cycle until stalls on the rsp side fill the pipeline and req_tready
// drops. The integral and previous-error state is updated in the state
// register stage, so consecutive ticks see each other's state without a
// gap. Registers are written through the csr port; the user must write
// them only while no tick is in flight; the block does not enforce this.
`default_nettype none

module dual_side_pid_drive
   import dspd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Tick input.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // left_front_position, left_back_position, right_front_position,
   // right_back_position, 24 bits each from the lowest bit up.
   input  wire logic [4*POS_W-1:0]   req_tdata,
   // restart.
   input  wire logic                 req_tuser,
   // Drive result.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // drive_left [7:0], drive_right [15:8].
   output logic [2*DRV_W-1:0]        rsp_tdata,
   // moving.
   output logic                      rsp_tuser,
   // Configuration writes.
   input  wire logic                 csr_we,
   input  wire logic [IDX_W-1:0]     csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int STAGES = 5;

   // Configuration registers.
   logic [POS_W-1:0]  target_left_ff;
   logic [POS_W-1:0]  target_right_ff;
   logic [LIM_W-1:0]  limit_left_ff;
   logic [LIM_W-1:0]  limit_right_ff;
   logic [GAIN_W-1:0] gain_p_ff;
   logic [GAIN_W-1:0] gain_i_ff;
   logic [GAIN_W-1:0] gain_d_ff;
   logic [ZONE_W-1:0] zone_ff;

   // Pipeline occupancy and flow control.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] free;
   logic [STAGES-1:0] adv;
   logic              in_acc;

   // Input and error stage payload.
   logic [4*POS_W-1:0] pos_ff;
   logic               restart_s0_ff;
   logic               restart_s1_ff;
   logic signed [ERR_W-1:0] err_left;
   logic signed [ERR_W-1:0] err_right;

   dspd_ctrl_type ctrl;
   logic [DRV_W-1:0] drive_left;
   logic [DRV_W-1:0] drive_right;
   logic             settled_left;
   logic             settled_right;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_left_ff  <= '0;
         target_right_ff <= '0;
         limit_left_ff   <= LIMIT_RESET;
         limit_right_ff  <= LIMIT_RESET;
         gain_p_ff       <= GAIN_P_RESET;
         gain_i_ff       <= GAIN_I_RESET;
         gain_d_ff       <= GAIN_D_RESET;
         zone_ff         <= ZONE_RESET;
      end else if (csr_we) begin
         unique case (dspd_csr_type'(csr_index))
            CSR_TARGET_LEFT:   target_left_ff  <= csr_wdata[POS_W-1:0];
            CSR_TARGET_RIGHT:  target_right_ff <= csr_wdata[POS_W-1:0];
            CSR_LIMIT_LEFT:    limit_left_ff   <= csr_wdata[LIM_W-1:0];
            CSR_LIMIT_RIGHT:   limit_right_ff  <= csr_wdata[LIM_W-1:0];
            CSR_GAIN_P:        gain_p_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:        gain_i_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:        gain_d_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_INTEGRAL_ZONE: zone_ff         <= csr_wdata[ZONE_W-1:0];
            default: ;
         endcase
      end
   end

   // A stage may take a beat when it is empty or its beat moves on.
   always_comb begin
      free[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      adv[STAGES-1]  = valid_ff[STAGES-1] && rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         free[k] = !valid_ff[k] || free[k+1];
         adv[k]  = valid_ff[k] && free[k+1];
      end
      in_acc      = req_tvalid && free[0];
      valid_in[0] = in_acc || (valid_ff[0] && !adv[0]);
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = adv[k-1] || (valid_ff[k] && !adv[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (in_acc) begin
         pos_ff        <= req_tdata;
         restart_s0_ff <= req_tuser;
      end
      if (adv[0]) begin
         restart_s1_ff <= restart_s0_ff;
      end
   end

   dspd_error u_error (
      .clock                (clock),
      .load                 (adv[0]),
      .target_left          ($signed(target_left_ff)),
      .target_right         ($signed(target_right_ff)),
      .left_front_position  ($signed(pos_ff[POS_W-1:0])),
      .left_back_position   ($signed(pos_ff[2*POS_W-1:POS_W])),
      .right_front_position ($signed(pos_ff[3*POS_W-1:2*POS_W])),
      .right_back_position  ($signed(pos_ff[4*POS_W-1:3*POS_W])),
      .err_left             (err_left),
      .err_right            (err_right)
   );

   // Strobes for the later stages.
   always_comb begin
      ctrl.restart  = restart_s1_ff;
      ctrl.ld_state = adv[1];
      ctrl.ld_prod  = adv[2];
      ctrl.ld_out   = adv[3];
   end

   dspd_side u_left (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .err           (err_left),
      .gain_p        (gain_p_ff),
      .gain_i        (gain_i_ff),
      .gain_d        (gain_d_ff),
      .integral_zone (zone_ff),
      .limit         (limit_left_ff),
      .drive         (drive_left),
      .settled       (settled_left)
   );

   dspd_side u_right (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .err           (err_right),
      .gain_p        (gain_p_ff),
      .gain_i        (gain_i_ff),
      .gain_d        (gain_d_ff),
      .integral_zone (zone_ff),
      .limit         (limit_right_ff),
      .drive         (drive_right),
      .settled       (settled_right)
   );

   assign req_tready = free[0];
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {drive_right, drive_left};
   assign rsp_tuser  = !(settled_left && settled_right);

endmodule

`default_nettype wire

### hdl/dspd_checker.sv
`default_nettype none

module dspd_checker
   import dspd_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tready,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [2*DRV_W-1:0]   rsp_tdata,
   input wire logic                 rsp_tuser
);

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat withdrawn while stalled");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // When the output side can move, the whole pipeline can take a tick.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("req_tready low although the output can drain");

   // Drive commands are clamped to at most 127 in magnitude.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DRV_W-1:0] != 8'h80) &&
                     (rsp_tdata[2*DRV_W-1:DRV_W] != 8'h80))
      else $error("drive command outside the clamp range");

   // No result is shown in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

endmodule

bind dual_side_pid_drive dspd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import dspd_pkg::*;

   localparam int PIPE_DRAIN      = 8;
   localparam int IDLE_LIMIT      = 2000;
   localparam int MAX_WAIT        = 18;
   localparam int PHASES          = 10;
   localparam int TICKS_PER_PHASE = 46;
   localparam longint POS_MAX      = (longint'(1) <<< (POS_W - 1)) - 1;
   localparam longint INTEGRAL_HIGH = (longint'(1) <<< (INT_W - 1)) - 1;
   localparam longint INTEGRAL_LOW  = -(longint'(1) <<< (INT_W - 1));

   // One control tick as the sender sees it.
   typedef struct {
      logic                    restart;
      logic signed [POS_W-1:0] left_front;
      logic signed [POS_W-1:0] left_back;
      logic signed [POS_W-1:0] right_front;
      logic signed [POS_W-1:0] right_back;
   } tick_type;

   // One drive command as the receiver sees it.
   typedef struct {
      logic [DRV_W-1:0] drive_left;
      logic [DRV_W-1:0] drive_right;
      logic             moving;
   } drive_type;

   // Mirrors the controller state and registers and keeps the drive commands
   // that are still on their way out of the pipeline.
   class drive_scoreboard;
      logic signed [POS_W-1:0] target_left  = '0;
      logic signed [POS_W-1:0] target_right = '0;
      logic [LIM_W-1:0]        limit_left   = LIMIT_RESET;
      logic [LIM_W-1:0]        limit_right  = LIMIT_RESET;
      logic [GAIN_W-1:0]       gain_p       = GAIN_P_RESET;
      logic [GAIN_W-1:0]       gain_i       = GAIN_I_RESET;
      logic [GAIN_W-1:0]       gain_d       = GAIN_D_RESET;
      logic [ZONE_W-1:0]       zone         = ZONE_RESET;
      longint                  last_error [2] = '{0, 0};
      longint                  integral [2]   = '{0, 0};
      drive_type               pending [$];
      int                      errors      = 0;
      int                      ticks       = 0;
      int                      restarts    = 0;
      int                      settled     = 0;
      int                      saturations = 0;

      function void set_register(dspd_csr_type index, logic [CSR_W-1:0] value);
         case (index)
            CSR_TARGET_LEFT:   target_left  = value[POS_W-1:0];
            CSR_TARGET_RIGHT:  target_right = value[POS_W-1:0];
            CSR_LIMIT_LEFT:    limit_left   = value[LIM_W-1:0];
            CSR_LIMIT_RIGHT:   limit_right  = value[LIM_W-1:0];
            CSR_GAIN_P:        gain_p       = value[GAIN_W-1:0];
            CSR_GAIN_I:        gain_i       = value[GAIN_W-1:0];
            CSR_GAIN_D:        gain_d       = value[GAIN_W-1:0];
            CSR_INTEGRAL_ZONE: zone         = value[ZONE_W-1:0];
            default: ;
         endcase
      endfunction

      function longint magnitude(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // One side of the controller: integrates inside the zone, forms the
      // floored gained sum, clamps it and tells whether the side has settled.
      function logic [DRV_W-1:0] side_drive(int s, longint err, logic [LIM_W-1:0] limit,
                                            output bit calm);
         longint der;
         longint acc;
         longint lim;
         der = err - last_error[s];
         lim = longint'(limit);
         if (magnitude(err) < longint'(zone)) begin
            acc = integral[s] + err;
            if (acc > INTEGRAL_HIGH) begin
               acc = INTEGRAL_HIGH;
               saturations++;
            end
            if (acc < INTEGRAL_LOW) begin
               acc = INTEGRAL_LOW;
               saturations++;
            end
            integral[s] = acc;
         end
         acc = longint'(gain_p) * err + longint'(gain_i) * integral[s]
             + longint'(gain_d) * der;
         acc = acc >>> FRAC_W;
         if (acc > lim) acc = lim;
         if (acc < -lim) acc = -lim;
         calm = magnitude(err) < longint'(ERR_SETTLE) && magnitude(der) < longint'(DER_SETTLE);
         last_error[s] = err;
         return acc[DRV_W-1:0];
      endfunction

      // Works out the drive command of an accepted tick.
      function void note_tick(tick_type t);
         longint    err_left;
         longint    err_right;
         bit        calm_left;
         bit        calm_right;
         drive_type d;
         err_left  = longint'(target_left)
                   - ((longint'(t.left_front) + longint'(t.left_back)) >>> 1);
         // The right encoders count backwards, so their average is negated.
         err_right = longint'(target_right)
                   + ((longint'(t.right_front) + longint'(t.right_back)) >>> 1);
         if (t.restart) begin
            integral   = '{0, 0};
            last_error = '{err_left, err_right};
            restarts++;
         end
         d.drive_left  = side_drive(0, err_left, limit_left, calm_left);
         d.drive_right = side_drive(1, err_right, limit_right, calm_right);
         d.moving      = !(calm_left && calm_right);
         if (!d.moving) settled++;
         pending.push_back(d);
         ticks++;
      endfunction

      function void report(string field, int want, int got);
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      // Compares a received drive command with the oldest one pending.
      function void check_drive(logic [2*DRV_W-1:0] data, logic moving);
         drive_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected drive beat, expected none, actual %h/%b",
                     $time, data, moving);
            return;
         end
         want = pending.pop_front();
         if (data[DRV_W-1:0] !== want.drive_left)
            report("drive_left", $signed(want.drive_left), $signed(data[DRV_W-1:0]));
         if (data[2*DRV_W-1:DRV_W] !== want.drive_right)
            report("drive_right", $signed(want.drive_right), $signed(data[2*DRV_W-1:DRV_W]));
         if (moving !== want.moving)
            report("moving", want.moving, moving);
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // left_front, left_back, right_front, right_back from the lowest bit up.
   logic [4*POS_W-1:0]    req_tdata   = '0;
   // restart.
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // drive_left, drive_right from the lowest bit up.
   logic [2*DRV_W-1:0]    rsp_tdata;
   // moving.
   logic                  rsp_tuser;
   logic                  csr_we      = 1'b0;
   logic [IDX_W-1:0]      csr_index   = '0;
   logic [CSR_W-1:0]      csr_wdata   = '0;

   bit                    req_calm    = 1'b0;
   bit                    rsp_calm    = 1'b0;
   int                    settings    = 0;
   drive_scoreboard       sb          = new;

   dual_side_pid_drive i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sends one tick after a random gap and notes it once the beat is taken.
   task automatic send_tick(tick_type t);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t.right_back, t.right_front, t.left_back, t.left_front};
      req_tuser  <= t.restart;
      do @(posedge clock); while (!req_tready);
      sb.note_tick(t);
   endtask

   // Holds off the sender until every pending drive command has come out.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_register(dspd_csr_type index, longint value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_W-1:0];
      @(posedge clock);
      sb.set_register(index, value[CSR_W-1:0]);
   endtask

   task automatic write_setting(longint tl, longint tr, longint ll, longint lr,
                                longint gp, longint gi, longint gd, longint iz);
      write_register(CSR_TARGET_LEFT, tl);
      write_register(CSR_TARGET_RIGHT, tr);
      write_register(CSR_LIMIT_LEFT, ll);
      write_register(CSR_LIMIT_RIGHT, lr);
      write_register(CSR_GAIN_P, gp);
      write_register(CSR_GAIN_I, gi);
      write_register(CSR_GAIN_D, gd);
      write_register(CSR_INTEGRAL_ZONE, iz);
      csr_we <= 1'b0;
      settings++;
   endtask

   function automatic tick_type make_tick(logic r, int lf, int lb, int rf, int rb);
      tick_type t;
      t.restart     = r;
      t.left_front  = POS_W'(lf);
      t.left_back   = POS_W'(lb);
      t.right_front = POS_W'(rf);
      t.right_back  = POS_W'(rb);
      return t;
   endfunction

   function automatic longint spread(longint amp);
      return longint'($urandom_range(0, 2 * amp)) - amp;
   endfunction

   function automatic longint pick_target();
      logic signed [POS_W-1:0] wide;
      wide = POS_W'($urandom);
      return ($urandom_range(0, 1) == 1) ? longint'(wide) : spread(1000);
   endfunction

   // Phase setting: reset values first, then the extremes, then random ones.
   task automatic apply_setting(int p);
      case (p)
         0: write_setting(0, 0, 127, 127, 102, 44, 64, 50);
         1: write_setting(spread(500), spread(500), 127, 127, 4095, 4095, 4095, 65535);
         2: write_setting(-POS_MAX - 1, POS_MAX, 0, 0, 0, 0, 0, 0);
         3: write_setting(POS_MAX, -POS_MAX - 1, 0, 127, $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
         4: write_setting(0, 0, 127, 1, 0, 4095, 0, 65535);
         default:
            write_setting(pick_target(), pick_target(), $urandom_range(0, 127),
                          $urandom_range(0, 127), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          ($urandom_range(0, 1) == 1) ? $urandom_range(0, 200)
                                                      : $urandom_range(0, 65535));
      endcase
   endtask

   // A move: a restart followed by ticks that close in on the targets (or
   // hold a fixed error), with some noise ticks and stray restarts mixed in.
   task automatic run_move();
      longint   amp;
      longint   dl;
      longint   dr;
      longint   skew;
      longint   base;
      int       len;
      bit       hold;
      tick_type t;
      case ($urandom_range(0, 3))
         0: amp = 12;
         1: amp = 200;
         2: amp = 70000;
         default: amp = 2 * POS_MAX;
      endcase
      dl       = spread(amp);
      dr       = spread(amp);
      hold     = ($urandom_range(0, 4) == 0);
      len      = $urandom_range(4, 24);
      req_calm = ($urandom_range(0, 3) == 0);
      rsp_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if (i > 0 && $urandom_range(0, 7) == 0) begin
            t.restart     = ($urandom_range(0, 3) == 0);
            t.left_front  = POS_W'($urandom);
            t.left_back   = POS_W'($urandom);
            t.right_front = POS_W'($urandom);
            t.right_back  = POS_W'($urandom);
         end else begin
            t.restart     = (i == 0) || ($urandom_range(0, 29) == 0);
            skew          = spread(3);
            base          = longint'(sb.target_left) - dl;
            t.left_front  = POS_W'(base + skew);
            t.left_back   = POS_W'(base - skew + longint'($urandom_range(0, 1)));
            skew          = spread(3);
            base          = dr - longint'(sb.target_right);
            t.right_front = POS_W'(base + skew);
            t.right_back  = POS_W'(base - skew + longint'($urandom_range(0, 1)));
         end
         send_tick(t);
         if (!hold) begin
            dl = dl * 3 / 4 + spread(1);
            dr = dr * 3 / 4 + spread(1);
         end
      end
   endtask

   // Result side: random stalls, each accepted beat checked in order.
   initial begin : drive_sink
      int stall;
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_drive(rsp_tdata, rsp_tuser);
      end
   end

   // Ends the run if neither side moves a beat for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("dual_side_pid_drive test failed");
      $finish;
   end

   initial begin : stimulus
      int  start;
      bit  paused;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: first tick without restart, settling and zone edges,
      // odd and negative encoder sums, and the extremes of the positions.
      send_tick(make_tick(1'b0, 100, -301, 7, 0));
      send_tick(make_tick(1'b1, 9, 10, -9, -10));
      send_tick(make_tick(1'b0, 9, 10, -9, -10));
      send_tick(make_tick(1'b0, 9, 9, -9, -9));
      send_tick(make_tick(1'b0, 4, 4, -9, -9));
      send_tick(make_tick(1'b0, 0, 0, 0, 0));
      send_tick(make_tick(1'b0, 0, 0, 0, 0));
      send_tick(make_tick(1'b0, 49, 49, -50, -50));
      send_tick(make_tick(1'b0, -49, -49, 50, 50));
      send_tick(make_tick(1'b0, 8388607, 8388607, 8388607, 8388607));
      send_tick(make_tick(1'b0, -8388608, -8388608, -8388608, -8388608));
      send_tick(make_tick(1'b1, 8388607, -8388608, -8388608, 8388607));
      send_tick(make_tick(1'b0, -1, 0, 0, -1));
      send_tick(make_tick(1'b0, 8388607, 8388607, -8388608, -8388608));
      send_tick(make_tick(1'b1, 0, 0, 0, 0));
      drain();

      // Extreme targets and gains, a zero limit and a zero zone.
      write_setting(-POS_MAX - 1, POS_MAX, 0, 127, 4095, 4095, 4095, 0);
      send_tick(make_tick(1'b1, 0, 0, 0, 0));
      send_tick(make_tick(1'b0, 8388607, 8388607, -8388608, -8388608));
      send_tick(make_tick(1'b0, -8388608, -8388608, 8388607, 8388607));
      send_tick(make_tick(1'b0, 0, 0, 0, 0));
      drain();

      // Random phases, each under its own register setting.
      for (int p = 0; p < PHASES; p++) begin
         apply_setting(p);
         start  = sb.ticks;
         paused = 1'b0;
         while (sb.ticks - start < TICKS_PER_PHASE) begin
            run_move();
            if (p == 5 && !paused && sb.ticks - start >= TICKS_PER_PHASE / 2) begin
               drain();
               paused = 1'b1;
            end
         end
         drain();
      end

      $display("Covered %0d ticks (%0d restarts) over %0d register settings.",
               sb.ticks, sb.restarts, settings);
      $display("Settled commands: %0d, integral saturations: %0d, mismatches: %0d.",
               sb.settled, sb.saturations, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("dual_side_pid_drive test passed");
      end else begin
         $display("dual_side_pid_drive test failed");
      end
      $finish;
   end

endmodule
